FILE: rtl/tnmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmm_pkg: shared types and constants of the top-n max/min tracker
// Holds the sequencer states, the list control group and the default sizes.
// ----------------------------------------------------------------------------
package tnmm_pkg;

   // defaults handed to the top-level parameters
   localparam int MAX_DEPTH_DEF    = 16;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // fixed field widths
   localparam int COUNT_W = 32;
   localparam int RANK_W  = 4;
   localparam int CFG_W   = 5;

   // list size after reset
   localparam int LIST_SIZE_RST = 8;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_APPEND,
      ST_QUERY,
      ST_WAIT
   } tnmm_state_type;

   // control of both sorted lists from the sequencer
   typedef struct packed {
      logic start;   // load the carry with the new sample
      logic rd;      // read both lists at the given address
      logic step;    // compare read entry, shift the carry through
      logic append;  // write the carry at the given address
   } tnmm_list_ctl_type;

endpackage : tnmm_pkg
`default_nettype wire

FILE: rtl/top_n_max_min_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_n_max_min_tracker: top-n largest and smallest values with running mean
// Keeps the list_size largest and smallest samples in sorted order, a running
// sum and a saturating count, and reports ranked values and the mean.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   sample, query_rank
//  rsp_      out        rsp_valid/rsp_stall   ranked values, mean, count
//  csr_      in         csr_valid/csr_ready   list_size
//
//  A request walks both lists entry by entry (a read and an update state per
//  entry held), then appends and reads the ranked entry; the bit-serial divider
//  for the mean runs beside the walk, and the result waits for both to finish.
//  Reset is synchronous; then list_size is min(8, MAX_DEPTH), both lists empty.
//  A finished result waits in the output register while rsp_stall is high;
//  the next request is taken meanwhile but cannot finish until it drains.
// ----------------------------------------------------------------------------
module top_n_max_min_tracker #(
   parameter int MAX_DEPTH    = tnmm_pkg::MAX_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = tnmm_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire  logic                             clock,
   input  wire  logic                             reset,

   input  wire  logic                             req_valid,
   output logic                                   req_stall,
   input  wire  logic signed [SAMPLE_WIDTH-1:0]   req_sample,
   input  wire  logic [tnmm_pkg::RANK_W-1:0]      req_query_rank,

   output logic                                   rsp_valid,
   input  wire  logic                             rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_largest_at_rank,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_smallest_at_rank,
   output logic                                   rsp_rank_valid,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_average,
   output logic [tnmm_pkg::COUNT_W-1:0]           rsp_sample_count,
   output logic                                   rsp_count_saturated,

   input  wire  logic                             csr_valid,
   output logic                                   csr_ready,
   input  wire  logic [tnmm_pkg::CFG_W-1:0]       csr_list_size
);

   import tnmm_pkg::*;

   localparam int ADDR_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int FILL_W   = $clog2(MAX_DEPTH + 1);
   localparam int SUM_W    = SAMPLE_WIDTH + COUNT_W;
   localparam int CMP_W    = RANK_W + FILL_W;
   localparam int SIZE_RST = (LIST_SIZE_RST > MAX_DEPTH) ? MAX_DEPTH : LIST_SIZE_RST;

   tnmm_state_type                 state_ff;
   tnmm_state_type                 state_in;
   tnmm_list_ctl_type              list_ctl;
   logic [ADDR_W-1:0]              list_addr;
   logic [ADDR_W-1:0]              idx_ff;
   logic [ADDR_W-1:0]              idx_in;
   logic [FILL_W-1:0]              fill_ff;
   logic [FILL_W-1:0]              fill_in;
   logic [FILL_W-1:0]              size_ff;
   logic [FILL_W-1:0]              size_in;
   logic signed [SUM_W-1:0]        sum_ff;
   logic signed [SUM_W-1:0]        sum_in;
   logic [COUNT_W-1:0]             count_ff;
   logic [COUNT_W-1:0]             count_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [RANK_W-1:0]              rank_ff;
   logic                           req_take;
   logic                           csr_take;
   logic                           load;
   logic                           rank_ok;
   logic                           div_busy;
   logic signed [SUM_W-1:0]        div_quot;
   logic signed [SAMPLE_WIDTH-1:0] big_q;
   logic signed [SAMPLE_WIDTH-1:0] small_q;

   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_largest_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_smallest_ff;
   logic                           rsp_rank_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_average_ff;
   logic [COUNT_W-1:0]             rsp_count_ff;
   logic                           rsp_sat_ff;

   // handshakes
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_take  = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign req_take  = req_valid && !req_stall;

   // list size clamped to the range 1 to the storage depth
   always_comb begin
      if (csr_list_size == '0) begin
         size_in = FILL_W'(1);
      end else if (int'(csr_list_size) > MAX_DEPTH) begin
         size_in = FILL_W'(MAX_DEPTH);
      end else begin
         size_in = FILL_W'(csr_list_size);
      end
   end

   // running sum and saturating count
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (count_ff != '1) begin
         sum_in   = sum_ff + {{(SUM_W - SAMPLE_WIDTH){req_sample[SAMPLE_WIDTH-1]}}, req_sample};
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      list_ctl = '0;
      list_addr = idx_ff;
      load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               list_ctl.start = 1'b1;
               idx_in         = '0;
               state_in       = (fill_ff == '0) ? ST_APPEND : ST_READ;
            end
         end
         ST_READ: begin
            list_ctl.rd = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            list_ctl.step = 1'b1;
            if (FILL_W'(idx_ff) + FILL_W'(1) == fill_ff) begin
               state_in = ST_APPEND;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_READ;
            end
         end
         ST_APPEND: begin
            list_addr = ADDR_W'(fill_ff);
            if (fill_ff < size_ff) begin
               list_ctl.append = 1'b1;
               fill_in         = fill_ff + FILL_W'(1);
            end
            state_in = ST_QUERY;
         end
         ST_QUERY: begin
            list_addr   = ADDR_W'(rank_ff);
            list_ctl.rd = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            if (!div_busy && (!rsp_valid_ff || !rsp_stall)) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         fill_ff  <= '0;
         size_ff  <= FILL_W'(SIZE_RST);
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_take) begin
            size_ff  <= size_in;
            fill_ff  <= '0;
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            fill_ff <= fill_in;
            if (req_take) begin
               sum_ff   <= sum_in;
               count_ff <= count_in;
            end
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_sample;
         rank_ff   <= req_query_rank;
      end
   end

   // sorted lists
   tnmm_lists #(
      .MAX_DEPTH    (MAX_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_lists (
      .clock      (clock),
      .reset      (reset),
      .ctl        (list_ctl),
      .addr       (list_addr),
      .sample     (req_take ? req_sample : sample_ff),
      .largest_q  (big_q),
      .smallest_q (small_q)
   );

   // mean of the samples so far, runs beside the list walk
   tnmm_div #(
      .DVD_W (SUM_W),
      .DVS_W (COUNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .dividend (sum_in),
      .divisor  (count_in),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // rank check against the filled entries
   assign rank_ok = CMP_W'(rank_ff) < CMP_W'(fill_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_largest_ff    <= rank_ok ? big_q : '1;
         rsp_smallest_ff   <= rank_ok ? small_q : '1;
         rsp_rank_valid_ff <= rank_ok;
         rsp_average_ff    <= div_quot[SAMPLE_WIDTH-1:0];
         rsp_count_ff      <= count_ff;
         rsp_sat_ff        <= &count_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_largest_at_rank  = rsp_largest_ff;
   assign rsp_smallest_at_rank = rsp_smallest_ff;
   assign rsp_rank_valid       = rsp_rank_valid_ff;
   assign rsp_average          = rsp_average_ff;
   assign rsp_sample_count     = rsp_count_ff;
   assign rsp_count_saturated  = rsp_sat_ff;

endmodule : top_n_max_min_tracker
`default_nettype wire

FILE: rtl/tnmm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmm_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit a cycle; quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tnmm_div #(
   parameter int DVD_W = 48,
   parameter int DVS_W = 32
) (
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   input  wire  logic                    start,
   input  wire  logic signed [DVD_W-1:0] dividend,
   input  wire  logic        [DVS_W-1:0] divisor,
   output logic                          busy,
   output logic signed [DVD_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic              busy_ff;
   logic              neg_ff;
   logic [DVD_W-1:0]  work_ff;
   logic [DVD_W-1:0]  work_in;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  rem_in;
   logic [DVS_W-1:0]  divisor_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DVS_W:0]    shifted;
   logic [DVS_W:0]    trial;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, work_ff[DVD_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
      if (!trial[DVS_W]) begin
         rem_in  = trial[DVS_W-1:0];
         work_in = {work_ff[DVD_W-2:0], 1'b1};
      end else begin
         rem_in  = shifted[DVS_W-1:0];
         work_in = {work_ff[DVD_W-2:0], 1'b0};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DVD_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath, magnitude division
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff     <= dividend[DVD_W-1];
         work_ff    <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed(work_ff) : $signed(work_ff);

endmodule : tnmm_div
`default_nettype wire

FILE: rtl/tnmm_lists.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmm_lists: descending and ascending sorted lists
// Two memories walked entry by entry; a carry register ripples the new sample
// in and pushes later entries down by one place.
// ----------------------------------------------------------------------------
module tnmm_lists #(
   parameter int MAX_DEPTH    = 16,
   parameter int SAMPLE_WIDTH = 16,
   parameter int ADDR_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
   input  wire  logic                           clock,
   input  wire  logic                           reset,
   input  wire  tnmm_pkg::tnmm_list_ctl_type    ctl,
   input  wire  logic [ADDR_W-1:0]              addr,
   input  wire  logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic signed [SAMPLE_WIDTH-1:0]       largest_q,
   output logic signed [SAMPLE_WIDTH-1:0]       smallest_q
);

   import tnmm_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] big_mem   [MAX_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] small_mem [MAX_DEPTH];

   logic signed [SAMPLE_WIDTH-1:0] big_rd_ff;
   logic signed [SAMPLE_WIDTH-1:0] small_rd_ff;
   logic signed [SAMPLE_WIDTH-1:0] big_carry_ff;
   logic signed [SAMPLE_WIDTH-1:0] small_carry_ff;
   logic                           big_ins_ff;
   logic                           small_ins_ff;
   logic                           big_take;
   logic                           small_take;

   // insertion point reached, or already passed
   assign big_take   = ctl.step && (big_ins_ff || (big_rd_ff < sample));
   assign small_take = ctl.step && (small_ins_ff || (small_rd_ff > sample));

   // memory ports
   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         big_rd_ff   <= big_mem[addr];
         small_rd_ff <= small_mem[addr];
      end
      if (ctl.append || big_take) begin
         big_mem[addr] <= big_carry_ff;
      end
      if (ctl.append || small_take) begin
         small_mem[addr] <= small_carry_ff;
      end
   end

   // carry values
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         big_carry_ff   <= sample;
         small_carry_ff <= sample;
      end else begin
         if (big_take) begin
            big_carry_ff <= big_rd_ff;
         end
         if (small_take) begin
            small_carry_ff <= small_rd_ff;
         end
      end
   end

   // insertion flags
   always_ff @(posedge clock) begin
      if (reset) begin
         big_ins_ff   <= 1'b0;
         small_ins_ff <= 1'b0;
      end else if (ctl.start) begin
         big_ins_ff   <= 1'b0;
         small_ins_ff <= 1'b0;
      end else begin
         if (big_take) begin
            big_ins_ff <= 1'b1;
         end
         if (small_take) begin
            small_ins_ff <= 1'b1;
         end
      end
   end

   assign largest_q  = big_rd_ff;
   assign smallest_q = small_rd_ff;

endmodule : tnmm_lists
`default_nettype wire
